### design/nfea_pkg.sv
// Shared constants and types for the next-fit extent allocator.
`timescale 1ns / 1ps

package nfea_pkg;

   localparam int NUM_EXTENTS = 4096;
   localparam int EXT_W       = $clog2(NUM_EXTENTS);
   localparam int CNT_W       = 13;
   localparam int OWNER_W     = 16;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int NUM_WORDS   = NUM_EXTENTS / WORD_W;
   localparam int WADDR_W     = $clog2(NUM_WORDS);
   localparam int COUNT_MAX   = 8191;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_BUSY    = 3'd2,
      ST_INVALID = 3'd3,
      ST_NOTSET  = 3'd4
   } status_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } scan_result_type;

endpackage

### design/nfea_word_scan.sv
// Finds the lowest clear bit of one bitmap word inside an inclusive bit window.
`timescale 1ns / 1ps

module nfea_word_scan (
   input  logic [nfea_pkg::WORD_W-1:0] word_data,
   input  logic [nfea_pkg::BIT_W-1:0]  lo_bit,
   input  logic [nfea_pkg::BIT_W-1:0]  hi_bit,
   output nfea_pkg::scan_result_type   result
);

   logic [nfea_pkg::WORD_W-1:0] lo_mask;
   logic [nfea_pkg::WORD_W-1:0] hi_mask;
   logic [nfea_pkg::WORD_W-1:0] free_bits;
   logic [nfea_pkg::BIT_W-1:0]  top_bit;

   assign top_bit   = nfea_pkg::BIT_W'(nfea_pkg::WORD_W - 1);
   assign lo_mask   = {nfea_pkg::WORD_W{1'b1}} << lo_bit;
   assign hi_mask   = {nfea_pkg::WORD_W{1'b1}} >> (top_bit - hi_bit);
   assign free_bits = ~word_data & lo_mask & hi_mask;

   // lowest set bit wins
   always_comb begin
      result.found = |free_bits;
      result.pos   = '0;
      for (int i = nfea_pkg::WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            result.pos = nfea_pkg::BIT_W'(i);
         end
      end
   end

endmodule

### design/next_fit_extent_allocator_unit.sv
// Top level: next-fit bitmap extent allocator with owner table.
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+---------------------------------------------------------
//  req_     | in  | tuser: mode; tdata: owner_id[15:0], extent_index[27:16]
//  rsp_     | out | tdata: status[2:0], granted_extent[14:3], stored_total[27:15]
//  csr_     | in  | csr_wdata: extent_count (13 bits)
//
// An allocate scans W bitmap words, W = 1..255 (32 bits per word; a wrapped
// search rereads the map from word 0), then checks the owner table. The bitmap
// memory's single read port, one word per cycle, sets the allocate time.
// After reset a clearing pass zeroes both memories; req_tready stays low
// during it. A finished result waits in the rsp register; the next
// transaction is taken while it waits, and the unit stalls only on delivery.
`timescale 1ns / 1ps

module next_fit_extent_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // owner_id[15:0], extent_index[27:16]
   input  logic [0:0]  req_tuser,   // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[2:0], granted_extent[14:3], stored_total[27:15]
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_OWNER,
      S_FREE,
      S_DONE
   } state_type;

   localparam int EW = nfea_pkg::EXT_W;
   localparam int CW = nfea_pkg::CNT_W;
   localparam int OW = nfea_pkg::OWNER_W;
   localparam int WW = nfea_pkg::WADDR_W;
   localparam int BW = nfea_pkg::BIT_W;

   // memories
   logic [nfea_pkg::WORD_W-1:0] map_mem [nfea_pkg::NUM_WORDS];
   logic [OW-1:0]               owner_mem [nfea_pkg::NUM_EXTENTS];

   logic                        map_we;
   logic [WW-1:0]               map_waddr;
   logic [nfea_pkg::WORD_W-1:0] map_wdata;
   logic [WW-1:0]               map_raddr;
   logic [nfea_pkg::WORD_W-1:0] map_rdata_ff;
   logic                        owner_we;
   logic [EW-1:0]               owner_waddr;
   logic [OW-1:0]               owner_wdata;
   logic [EW-1:0]               owner_raddr;
   logic [OW-1:0]               owner_rdata_ff;

   // control and payload registers
   state_type            state_ff, state_in;
   logic [EW-1:0]        clr_ff, clr_in;
   logic [EW-1:0]        start_ff, start_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        csr_ff, csr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   logic [OW-1:0]        owner_ff, owner_in;
   logic [EW-1:0]        idx_ff, idx_in;
   logic [EW-1:0]        nm1_ff, nm1_in;
   logic [WW-1:0]        word_ff, word_in;
   logic                 pass2_ff, pass2_in;
   logic [EW-1:0]        bit_ff, bit_in;
   logic [EW-1:0]        id_ff, id_in;
   nfea_pkg::status_type res_status_ff, res_status_in;
   logic [EW-1:0]        res_grant_ff, res_grant_in;

   logic [OW-1:0]             req_owner;
   logic [EW-1:0]             req_idx;
   logic [CW-1:0]             n_now;
   logic [BW-1:0]             scan_lo;
   logic [BW-1:0]             scan_hi;
   logic                      scan_last;
   nfea_pkg::scan_result_type scan_res;
   logic [EW-1:0]             found_bit;
   logic [nfea_pkg::WORD_W-1:0] bit_onehot;

   assign req_owner  = req_tdata[OW-1:0];
   assign req_idx    = req_tdata[OW+EW-1:OW];
   assign n_now      = (csr_ff > CW'(nfea_pkg::NUM_EXTENTS)) ? CW'(nfea_pkg::NUM_EXTENTS)
                                                             : csr_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // window of the current word: from the start bit upward on the first pass, up to n-1
   assign scan_last = (word_ff == nm1_ff[EW-1:BW]);
   assign scan_lo   = (!pass2_ff && word_ff == start_ff[EW-1:BW]) ? start_ff[BW-1:0] : '0;
   assign scan_hi   = scan_last ? nm1_ff[BW-1:0] : BW'(nfea_pkg::WORD_W - 1);
   assign found_bit = {word_ff, scan_res.pos};
   assign bit_onehot = {{(nfea_pkg::WORD_W-1){1'b0}}, 1'b1} << bit_ff[BW-1:0];

   nfea_word_scan u_scan (
      .word_data (map_rdata_ff),
      .lo_bit    (scan_lo),
      .hi_bit    (scan_hi),
      .result    (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      csr_in        = csr_we ? csr_wdata : csr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      owner_in      = owner_ff;
      idx_in        = idx_ff;
      nm1_in        = nm1_ff;
      word_in       = word_ff;
      pass2_in      = pass2_ff;
      bit_in        = bit_ff;
      id_in         = id_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;

      map_we      = 1'b0;
      map_waddr   = word_ff;
      map_wdata   = map_rdata_ff;
      owner_we    = 1'b0;
      owner_waddr = id_ff;
      owner_wdata = owner_ff;
      owner_raddr = id_ff;

      unique case (state_ff)
         S_CLEAR: begin
            owner_we    = 1'b1;
            owner_waddr = clr_ff;
            owner_wdata = '0;
            if (clr_ff < EW'(nfea_pkg::NUM_WORDS)) begin
               map_we    = 1'b1;
               map_waddr = clr_ff[WW-1:0];
               map_wdata = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == EW'(nfea_pkg::NUM_EXTENTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               owner_in = req_owner;
               idx_in   = req_idx;
               nm1_in   = EW'(n_now - 1'b1);
               if (req_tuser[0] == nfea_pkg::MODE_ALLOC) begin
                  res_grant_in = '0;
                  if (req_owner == '0) begin
                     res_status_in = nfea_pkg::ST_INVALID;
                     state_in      = S_DONE;
                  end else if (n_now == '0) begin
                     res_status_in = nfea_pkg::ST_NOSPACE;
                     state_in      = S_DONE;
                  end else if ({1'b0, start_ff} >= n_now) begin
                     // stale start point: go straight to the wrapped pass
                     pass2_in = 1'b1;
                     word_in  = '0;
                     state_in = S_SCAN;
                  end else begin
                     pass2_in = 1'b0;
                     word_in  = start_ff[EW-1:BW];
                     state_in = S_SCAN;
                  end
               end else begin
                  res_grant_in = req_idx;
                  if ({1'b0, req_idx} >= n_now) begin
                     res_status_in = nfea_pkg::ST_INVALID;
                     state_in      = S_DONE;
                  end else begin
                     bit_in   = EW'(n_now - 1'b1) - req_idx;
                     word_in  = bit_in[EW-1:BW];
                     state_in = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               bit_in      = found_bit;
               id_in       = nm1_ff - found_bit;
               owner_raddr = id_in;
               state_in    = S_OWNER;
            end else if (scan_last) begin
               if (!pass2_ff && start_ff != '0) begin
                  pass2_in = 1'b1;
                  word_in  = '0;
               end else begin
                  res_status_in = nfea_pkg::ST_NOSPACE;
                  res_grant_in  = '0;
                  state_in      = S_DONE;
               end
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         S_OWNER: begin
            res_grant_in = id_ff;
            if (owner_rdata_ff != '0) begin
               res_status_in = nfea_pkg::ST_BUSY;
            end else begin
               res_status_in = nfea_pkg::ST_OK;
               owner_we      = 1'b1;
               map_we        = 1'b1;
               map_wdata     = map_rdata_ff | bit_onehot;
               start_in      = bit_ff;
               if (count_ff != CW'(nfea_pkg::COUNT_MAX)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = S_DONE;
         end
         S_FREE: begin
            owner_we      = 1'b1;
            owner_waddr   = idx_ff;
            owner_wdata   = '0;
            map_we        = 1'b1;
            map_wdata     = map_rdata_ff & ~bit_onehot;
            res_status_in = (|(map_rdata_ff & bit_onehot)) ? nfea_pkg::ST_OK
                                                          : nfea_pkg::ST_NOTSET;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, count_ff, res_grant_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      map_raddr = word_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rdata_ff <= map_mem[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_waddr] <= owner_wdata;
      end
      owner_rdata_ff <= owner_mem[owner_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         csr_ff       <= CW'(nfea_pkg::NUM_EXTENTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      owner_ff      <= owner_in;
      idx_ff        <= idx_in;
      nm1_ff        <= nm1_in;
      word_ff       <= word_in;
      pass2_ff      <= pass2_in;
      bit_ff        <= bit_in;
      id_ff         <= id_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
   end

endmodule
